/* hdl/rmj_pkg.sv */
// Shared widths, sideband types and the output saturation function.
package rmj_pkg;

    localparam int IN_W  = 32;            // input and output field width
    localparam int C_W   = 64;            // squared range px^2+py^2, Q32.32
    localparam int R_W   = 48;            // range, Q16.32
    localparam int Q_W   = 32;            // quotient bits kept below the overflow check
    localparam int CR_W  = C_W + R_W;     // squared range times range
    localparam int PD_W  = IN_W + C_W;    // position times cross term

    localparam logic [IN_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [IN_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic dneg;
        logic mx_nz;
        logic my_nz;
        logic d_nz;
        logic tc;
    } t_flag;

    typedef struct packed {
        logic [IN_W-1:0] mx;
        logic [IN_W-1:0] my;
        logic [C_W-1:0]  dmag;
        t_flag           flags;
    } t_side;

    // Clamp a magnitude quotient with its sign to signed Q16.16.
    function automatic logic [IN_W-1:0] sat_q(input logic [Q_W-1:0] q,
                                              input logic big,
                                              input logic neg);
        logic [IN_W-1:0] v;
        if (!neg) begin
            v = (big || q[Q_W-1]) ? SAT_POS : q;
        end else begin
            v = (big || (q > SAT_NEG)) ? SAT_NEG : (~q + 1'b1);
        end
        return v;
    endfunction

endpackage

/* hdl/rmj_sqrt.sv */
// Pipelined digit-by-digit square root of the squared range, one result bit per stage.
module rmj_sqrt #(
    parameter int SW = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [rmj_pkg::C_W-1:0]  i_c,
    input  logic [SW-1:0]            i_side,
    output logic                     o_valid,
    output logic [rmj_pkg::R_W-1:0]  o_root,
    output logic [rmj_pkg::C_W-1:0]  o_c,
    output logic [SW-1:0]            o_side
);
    import rmj_pkg::*;

    localparam int PAD = 2 * R_W - C_W;

    logic             r_valid [R_W];
    logic [R_W-1:0]   r_res   [R_W];
    logic [R_W+1:0]   r_rem   [R_W];
    logic [C_W-1:0]   r_c     [R_W];
    logic [SW-1:0]    r_side  [R_W];

    for (genvar k = 0; k < R_W; k++) begin : g_stage
        localparam int B = R_W - 1 - k;
        logic             v_in;
        logic [R_W-1:0]   res_in;
        logic [R_W+1:0]   rem_in;
        logic [C_W-1:0]   c_in;
        logic [SW-1:0]    side_in;
        logic [2*R_W-1:0] rad;
        logic [R_W+1:0]   rem_sh;
        logic [R_W+1:0]   trial;
        logic             ge;
        logic [R_W+1:0]   n_rem;
        logic [R_W-1:0]   n_res;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign res_in  = '0;
            assign rem_in  = '0;
            assign c_in    = i_c;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_valid[k-1];
            assign res_in  = r_res[k-1];
            assign rem_in  = r_rem[k-1];
            assign c_in    = r_c[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            rad    = {c_in, {PAD{1'b0}}};
            rem_sh = {rem_in[R_W-1:0], rad[2*B+1 -: 2]};
            trial  = {res_in, 2'b01};
            ge     = rem_sh >= trial;
            n_rem  = ge ? (rem_sh - trial) : rem_sh;
            n_res  = {res_in[R_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= v_in;
            end
            if (i_en) begin
                r_res[k]  <= n_res;
                r_rem[k]  <= n_rem;
                r_c[k]    <= c_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[R_W-1];
    assign o_root  = r_res[R_W-1];
    assign o_c     = r_c[R_W-1];
    assign o_side  = r_side[R_W-1];

endmodule

/* hdl/rmj_div.sv */
// Pipelined restoring divider: floor(a * 2^Q_W / d) with an overflow flag, one bit per stage.
module rmj_div #(
    parameter int AW = 32,
    parameter int DW = 48
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [AW-1:0]            i_a,
    input  logic [DW-1:0]            i_d,
    output logic                     o_big,
    output logic [rmj_pkg::Q_W-1:0]  o_q
);
    import rmj_pkg::*;

    logic             r_big [Q_W+1];
    logic [DW-1:0]    r_rem [Q_W+1];
    logic [DW-1:0]    r_d   [Q_W+1];
    logic [Q_W-1:0]   r_q   [Q_W+1];

    // quotient reaches 2^Q_W exactly when a >= d; otherwise a is the first remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_big[0] <= DW'(i_a) >= i_d;
            r_rem[0] <= DW'(i_a);
            r_d[0]   <= i_d;
            r_q[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_step
        logic [DW:0]   t;
        logic          ge;
        logic [DW:0]   diff;
        logic [DW-1:0] n_rem;

        always_comb begin
            t     = {r_rem[k-1], 1'b0};
            diff  = t - {1'b0, r_d[k-1]};
            ge    = !diff[DW];
            n_rem = ge ? diff[DW-1:0] : t[DW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_big[k] <= r_big[k-1];
                r_rem[k] <= n_rem;
                r_d[k]   <= r_d[k-1];
                r_q[k]   <= {r_q[k-1][Q_W-2:0], ge};
            end
        end
    end

    assign o_big = r_big[Q_W];
    assign o_q   = r_q[Q_W];

endmodule

/* hdl/radar_measurement_jacobian.sv */
// Radar range/bearing/range-rate Jacobian entries from a constant-velocity state.
// Pipeline: 2 product/sum stages, 48 root stages, 2 partial-product stages,
// 33 divider stages and 1 output register.
// Throughput: one request per cycle; the whole pipeline holds while the output stalls.
// Reset: synchronous active low; clears all valid bits and sets min_range_sq to 7.
module radar_measurement_jacobian (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [31:0]               i_cfg_wdata,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [31:0]        i_pos_x,
    input  logic signed [31:0]        i_pos_y,
    input  logic signed [31:0]        i_vel_x,
    input  logic signed [31:0]        i_vel_y,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [31:0]        o_range_by_px,
    output logic signed [31:0]        o_range_by_py,
    output logic signed [31:0]        o_bearing_by_px,
    output logic signed [31:0]        o_bearing_by_py,
    output logic signed [31:0]        o_rate_by_px,
    output logic signed [31:0]        o_rate_by_py,
    output logic                      o_too_close
);
    import rmj_pkg::*;

    logic adv;
    logic [31:0] r_min_range_sq;

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range_sq <= 32'd7;
        end else if (i_cfg_we) begin
            r_min_range_sq <= i_cfg_wdata;
        end
    end

    // stage 1: magnitudes and 32x32 products
    logic                   r1_valid;
    logic [IN_W-1:0]        r1_mx, r1_my;
    logic                   r1_xneg, r1_yneg;
    logic [C_W-1:0]         r1_sqx, r1_sqy;
    logic signed [C_W-1:0]  r1_t1, r1_t2;
    logic [IN_W-1:0]        mx_in, my_in;

    assign mx_in = i_pos_x[IN_W-1] ? (~i_pos_x + 1'b1) : i_pos_x;
    assign my_in = i_pos_y[IN_W-1] ? (~i_pos_y + 1'b1) : i_pos_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= i_valid;
        end
        if (adv) begin
            r1_mx   <= mx_in;
            r1_my   <= my_in;
            r1_xneg <= i_pos_x[IN_W-1];
            r1_yneg <= i_pos_y[IN_W-1];
            r1_sqx  <= C_W'(mx_in) * C_W'(mx_in);
            r1_sqy  <= C_W'(my_in) * C_W'(my_in);
            r1_t1   <= C_W'(i_vel_x) * C_W'(i_pos_y);
            r1_t2   <= C_W'(i_vel_y) * C_W'(i_pos_x);
        end
    end

    // stage 2: squared range, cross term, near-origin check
    logic            r2_valid;
    logic [C_W-1:0]  r2_c;
    t_side           r2_side;
    logic [C_W-1:0]  c_sum;
    logic [C_W:0]    d_diff;
    logic [C_W-1:0]  d_mag;
    logic            d_neg;
    t_flag           fl2;

    always_comb begin
        c_sum  = r1_sqx + r1_sqy;
        d_diff = {r1_t1[C_W-1], r1_t1} - {r1_t2[C_W-1], r1_t2};
        d_neg  = d_diff[C_W];
        d_mag  = d_neg ? C_W'(~d_diff + 1'b1) : d_diff[C_W-1:0];
        fl2.xneg  = r1_xneg;
        fl2.yneg  = r1_yneg;
        fl2.dneg  = d_neg;
        fl2.mx_nz = r1_mx != '0;
        fl2.my_nz = r1_my != '0;
        fl2.d_nz  = d_mag != '0;
        fl2.tc    = (c_sum == '0) || (c_sum < C_W'({r_min_range_sq, 16'h0000}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv) begin
            r2_valid <= r1_valid;
        end
        if (adv) begin
            r2_c         <= c_sum;
            r2_side.mx   <= r1_mx;
            r2_side.my   <= r1_my;
            r2_side.dmag <= d_mag;
            r2_side.flags <= fl2;
        end
    end

    // range root
    logic            s_valid;
    logic [R_W-1:0]  s_root;
    logic [C_W-1:0]  s_c;
    t_side           s_side;

    rmj_sqrt #(
        .SW ($bits(t_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r2_valid),
        .i_c     (r2_c),
        .i_side  (r2_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_c     (s_c),
        .o_side  (s_side)
    );

    // stage M1: partial products of c*r and position*cross term
    logic            r3_valid;
    logic [R_W-1:0]  r3_root;
    logic [C_W-1:0]  r3_c;
    t_side           r3_side;
    logic [63:0]     r3_cr00, r3_cr10;
    logic [47:0]     r3_cr01, r3_cr11;
    logic [63:0]     r3_py0, r3_py1, r3_px0, r3_px1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (adv) begin
            r3_valid <= s_valid;
        end
        if (adv) begin
            r3_root <= s_root;
            r3_c    <= s_c;
            r3_side <= s_side;
            r3_cr00 <= 64'(s_c[31:0])  * 64'(s_root[31:0]);
            r3_cr01 <= 48'(s_c[31:0])  * 48'(s_root[R_W-1:32]);
            r3_cr10 <= 64'(s_c[63:32]) * 64'(s_root[31:0]);
            r3_cr11 <= 48'(s_c[63:32]) * 48'(s_root[R_W-1:32]);
            r3_py0  <= 64'(s_side.my) * 64'(s_side.dmag[31:0]);
            r3_py1  <= 64'(s_side.my) * 64'(s_side.dmag[63:32]);
            r3_px0  <= 64'(s_side.mx) * 64'(s_side.dmag[31:0]);
            r3_px1  <= 64'(s_side.mx) * 64'(s_side.dmag[63:32]);
        end
    end

    // stage M2: sum the partial products
    logic             r4_valid;
    logic [R_W-1:0]   r4_root;
    logic [C_W-1:0]   r4_c;
    logic [IN_W-1:0]  r4_mx, r4_my;
    t_flag            r4_flags;
    logic [CR_W-1:0]  r4_cr;
    logic [PD_W-1:0]  r4_py, r4_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (adv) begin
            r4_valid <= r3_valid;
        end
        if (adv) begin
            r4_root  <= r3_root;
            r4_c     <= r3_c;
            r4_mx    <= r3_side.mx;
            r4_my    <= r3_side.my;
            r4_flags <= r3_side.flags;
            r4_cr    <= CR_W'(r3_cr00) + (CR_W'(r3_cr01) << 32)
                      + (CR_W'(r3_cr10) << 32) + (CR_W'(r3_cr11) << 64);
            r4_py    <= PD_W'(r3_py0) + (PD_W'(r3_py1) << 32);
            r4_px    <= PD_W'(r3_px0) + (PD_W'(r3_px1) << 32);
        end
    end

    // six quotients in parallel
    logic [5:0]      q_big;
    logic [Q_W-1:0]  q_val [6];

    rmj_div #(.AW(IN_W), .DW(R_W)) u_div_rpx (
        .i_clk(i_clk), .i_en(adv), .i_a(r4_mx), .i_d(r4_root),
        .o_big(q_big[0]), .o_q(q_val[0]));
    rmj_div #(.AW(IN_W), .DW(R_W)) u_div_rpy (
        .i_clk(i_clk), .i_en(adv), .i_a(r4_my), .i_d(r4_root),
        .o_big(q_big[1]), .o_q(q_val[1]));
    rmj_div #(.AW(IN_W), .DW(C_W)) u_div_bpx (
        .i_clk(i_clk), .i_en(adv), .i_a(r4_my), .i_d(r4_c),
        .o_big(q_big[2]), .o_q(q_val[2]));
    rmj_div #(.AW(IN_W), .DW(C_W)) u_div_bpy (
        .i_clk(i_clk), .i_en(adv), .i_a(r4_mx), .i_d(r4_c),
        .o_big(q_big[3]), .o_q(q_val[3]));
    rmj_div #(.AW(PD_W), .DW(CR_W)) u_div_vpx (
        .i_clk(i_clk), .i_en(adv), .i_a(r4_py), .i_d(r4_cr),
        .o_big(q_big[4]), .o_q(q_val[4]));
    rmj_div #(.AW(PD_W), .DW(CR_W)) u_div_vpy (
        .i_clk(i_clk), .i_en(adv), .i_a(r4_px), .i_d(r4_cr),
        .o_big(q_big[5]), .o_q(q_val[5]));

    // carry valid and sign flags alongside the dividers
    logic   r5_valid [Q_W+1];
    t_flag  r5_flags [Q_W+1];

    for (genvar k = 0; k <= Q_W; k++) begin : g_delay
        logic  v_in;
        t_flag f_in;
        if (k == 0) begin : g_first
            assign v_in = r4_valid;
            assign f_in = r4_flags;
        end else begin : g_next
            assign v_in = r5_valid[k-1];
            assign f_in = r5_flags[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r5_valid[k] <= 1'b0;
            end else if (adv) begin
                r5_valid[k] <= v_in;
            end
            if (adv) begin
                r5_flags[k] <= f_in;
            end
        end
    end

    // output stage: sign, saturate, zero when too close
    t_flag           fo;
    logic [IN_W-1:0] n_out [6];

    always_comb begin
        fo = r5_flags[Q_W];
        n_out[0] = sat_q(q_val[0], q_big[0], fo.xneg);
        n_out[1] = sat_q(q_val[1], q_big[1], fo.yneg);
        n_out[2] = sat_q(q_val[2], q_big[2], !fo.yneg && fo.my_nz);
        n_out[3] = sat_q(q_val[3], q_big[3], fo.xneg);
        n_out[4] = sat_q(q_val[4], q_big[4], fo.yneg != fo.dneg);
        n_out[5] = sat_q(q_val[5], q_big[5],
                         (fo.xneg == fo.dneg) && fo.mx_nz && fo.d_nz);
        if (fo.tc) begin
            for (int i = 0; i < 6; i++) begin
                n_out[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= r5_valid[Q_W];
        end
        if (adv) begin
            o_range_by_px   <= n_out[0];
            o_range_by_py   <= n_out[1];
            o_bearing_by_px <= n_out[2];
            o_bearing_by_py <= n_out[3];
            o_rate_by_px    <= n_out[4];
            o_rate_by_py    <= n_out[5];
            o_too_close     <= fo.tc;
        end
    end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the radar measurement Jacobian block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 300;

    typedef logic [6:0][31:0] t_jac;

    class jacobian_board;
        logic [31:0] min_range_sq;
        t_jac        jac_q[$];
        int          errors;

        function new();
            min_range_sq = 32'd7;
            errors = 0;
        endfunction

        function logic [31:0] clamp(logic [191:0] q, logic neg);
            logic big;
            big = (q[191:32] != 0);
            if (!neg)
                return (big || q[31:0] > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
            return (big || q[31:0] > 32'h8000_0000) ? 32'h8000_0000 : (~q[31:0] + 1'b1);
        endfunction

        // Compute the expected Jacobian entries for one accepted request.
        function void note(logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] vx, logic signed [31:0] vy);
            logic [63:0] mx, my, c, r, cand, dmag;
            logic [127:0] rad, sq;
            logic signed [64:0] t1, t2, d;
            logic [191:0] rw, cw, cr, nx, ny, wx, wy, wd;
            logic dneg;
            t_jac e;
            mx = x[31] ? (~{{32{x[31]}}, x} + 64'd1) : {32'd0, x};
            my = y[31] ? (~{{32{y[31]}}, y} + 64'd1) : {32'd0, y};
            c = mx * mx + my * my;
            e = '0;
            if (c == 0 || c < {16'd0, min_range_sq, 16'd0}) begin
                e[6] = 32'd1;
                jac_q.push_back(e);
                return;
            end
            rad = {c, 32'd0};
            r = 0;
            for (int b = 63; b >= 0; b--) begin
                cand = r | (64'd1 << b);
                sq = {64'd0, cand} * {64'd0, cand};
                if (sq <= rad) r = cand;
            end
            t1 = vx * y;
            t2 = vy * x;
            d = t1 - t2;
            dneg = d < 0;
            dmag = dneg ? 64'(-d) : 64'(d);
            rw = {128'd0, r};
            cw = {128'd0, c};
            cr = cw * rw;
            wx = {128'd0, mx};
            wy = {128'd0, my};
            wd = {128'd0, dmag};
            nx = wx << 32;
            ny = wy << 32;
            e[0] = clamp(nx / rw, x[31]);
            e[1] = clamp(ny / rw, y[31]);
            e[2] = clamp(ny / cw, !y[31] && my != 0);
            e[3] = clamp(nx / cw, x[31]);
            e[4] = clamp(((wy * wd) << 32) / cr, y[31] != dneg);
            e[5] = clamp(((wx * wd) << 32) / cr, (x[31] == dneg) && mx != 0 && dmag != 0);
            jac_q.push_back(e);
        endfunction

        function void check(t_jac got);
            string names[7] = '{"range_by_px", "range_by_py", "bearing_by_px",
                                "bearing_by_py", "rate_by_px", "rate_by_py", "too_close"};
            t_jac e;
            if (jac_q.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            e = jac_q.pop_front();
            for (int i = 0; i < 7; i++)
                if (e[i] !== got[i]) begin
                    $display("%0t %s mismatch: expected %h actual %h",
                             $time, names[i], e[i], got[i]);
                    errors++;
                end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_vel_x = '0, i_vel_y = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [31:0] o_range_by_px, o_range_by_py, o_bearing_by_px, o_bearing_by_py;
    logic signed [31:0] o_rate_by_px, o_rate_by_py;
    logic        o_too_close;

    jacobian_board board = new();
    int  send_idle = 32;
    int  recv_idle = 62;
    bit  hold_arm = 0;
    bit  hold_done = 0;
    int  hold_left = 0;
    int  cycles = 0;

    radar_measurement_jacobian u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_vel_x(i_vel_x), .i_vel_y(i_vel_y),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_range_by_px(o_range_by_px), .o_range_by_py(o_range_by_py),
        .o_bearing_by_px(o_bearing_by_px), .o_bearing_by_py(o_bearing_by_py),
        .o_rate_by_px(o_rate_by_px), .o_rate_by_py(o_rate_by_py),
        .o_too_close(o_too_close)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL radar_measurement_jacobian");
            $finish;
        end
    end

    // Receiver: random stall, one long hold-off when armed, check accepted results.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check({31'd0, o_too_close, o_rate_by_py, o_rate_by_px, o_bearing_by_py,
                         o_bearing_by_px, o_range_by_py, o_range_by_px});
        if (hold_arm && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic send_req(logic [31:0] x, logic [31:0] y, logic [31:0] vx, logic [31:0] vy);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= x;
        i_pos_y <= y;
        i_vel_x <= vx;
        i_vel_y <= vy;
        do @(posedge i_clk); while (o_stall);
        board.note(x, y, vx, vy);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.jac_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.min_range_sq = v;
    endtask

    function automatic logic [31:0] pick_field(int kind);
        case (kind)
            0: return $urandom;
            1: return $urandom_range(1, 32'h1000) * ($urandom_range(1) ? -1 : 1);
            2: return $urandom_range(0, 32'h30000) * ($urandom_range(1) ? -1 : 1);
            default: begin
                case ($urandom_range(4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'd1;
                    default: return 32'd0;
                endcase
            end
        endcase
    endfunction

    task automatic random_batch(int count);
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(9);
            kind = (kind < 4) ? 0 : (kind < 7) ? 1 : (kind < 9) ? 2 : 3;
            send_req(pick_field(kind), pick_field(kind), pick_field($urandom_range(3)),
                     pick_field($urandom_range(3)));
        end
    endtask

    initial begin
        logic [31:0] thresholds[4];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // origin, near the default threshold, extremes, saturating bearing and rate
        send_req(32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_req(32'd1, 32'd0, 32'd1, 32'd1);
        send_req(32'd677, 32'd0, 32'd5, 32'd7);
        send_req(32'd678, 32'd0, 32'd5, 32'd7);
        send_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_req(32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000);
        send_req(32'd0, 32'hFFFF_0000, 32'h0001_0000, 32'd0);
        send_req(32'd1024, 32'd0, 32'd0, 32'h7FFF_FFFF);
        send_req(32'd0, 32'hFFFF_FC00, 32'h8000_0000, 32'd0);
        send_req(32'd700, 32'd700, 32'h7FFF_FFFF, 32'h8000_0000);
        send_req(32'hFFFF_FD00, 32'd800, 32'h8000_0000, 32'h7FFF_FFFF);
        send_req(32'h0003_0000, 32'h0004_0000, 32'h0004_0000, 32'hFFFD_0000);
        send_req(32'h0003_0000, 32'h0004_0000, 32'h0003_0000, 32'h0004_0000);
        send_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        drain();

        thresholds = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'd7};
        for (int p = 0; p < 4; p++) begin
            write_threshold(thresholds[p]);
            if (p == 1) begin
                send_idle = 62;
                recv_idle = 32;
            end else if (p == 2) begin
                send_idle = 0;
                recv_idle = 0;
                hold_arm = 1;
            end
            if (p == 1)
                send_req(32'h0080_0000, 32'd0, 32'd3, 32'd4);
            random_batch(445);
            drain();
        end
        write_threshold(32'd0);
        send_req(32'd0, 32'd0, 32'd9, 32'd9);
        drain();

        if (board.errors == 0)
            $display("PASS radar_measurement_jacobian");
        else
            $display("FAIL radar_measurement_jacobian");
        $finish;
    end
endmodule

/* filelist.f */
hdl/rmj_pkg.sv
hdl/rmj_sqrt.sv
hdl/rmj_div.sv
hdl/radar_measurement_jacobian.sv
tb/testbench.sv
